@@ rtl/assert_macros.svh @@
// Assertion macros for the vector unit RTL.
// Needs clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define VAU_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("vau assertion failed");
`define VAU_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("vau forbidden condition seen");
`else
`define VAU_CHECK(lbl, prop)
`define VAU_NEVER(lbl, expr)
`endif
`endif

@@ rtl/vau_pkg.sv @@
// Shared widths, operation codes, payload struct and clamp function.
// No dependencies.
package vau_pkg;

  localparam int DW       = 32;          // Q16.16 field width
  localparam int FW       = 16;          // fraction bits
  localparam int AB_W     = DW + 1;      // add/sub result
  localparam int P_W      = 2 * DW;      // product, sum of squares
  localparam int W_W      = P_W + 2;     // sum of three products
  localparam int NLANE    = 3;
  localparam int NMUL     = 6;
  localparam int SQ_STEPS = DW;          // one root bit per stage
  localparam int LEN_W    = DW + 1;      // rounded length
  localparam int Q_W      = FW + 1;      // normalize quotient, at most 2^FW
  localparam int NUM_W    = DW + FW;     // normalize dividend
  localparam int DIV_W    = LEN_W + Q_W; // divider compare width

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_SUB   = 3'd1,
    OP_SCALE = 3'd2,
    OP_DOT   = 3'd3,
    OP_CROSS = 3'd4,
    OP_LEN   = 3'd5,
    OP_NORM  = 3'd6
  } op_t;

  // Result and the a vector, carried down the whole pipeline.
  typedef struct packed {
    op_t                   op;
    logic signed [DW-1:0]  rx;
    logic signed [DW-1:0]  ry;
    logic signed [DW-1:0]  rz;
    logic signed [DW-1:0]  rs;
    logic                  sat;
    logic signed [DW-1:0]  ax;
    logic signed [DW-1:0]  ay;
    logic signed [DW-1:0]  az;
  } pl_t;

  // Returns {clamped flag, value clamped to the signed DW range}.
  function automatic logic [DW:0] sat_clamp(input logic signed [W_W-1:0] v);
    logic signed [W_W-1:0] hi;
    logic signed [W_W-1:0] lo;
    logic [DW:0]           r;
    hi = W_W'({1'b0, {(DW-1){1'b1}}});
    lo = -hi - W_W'(1);
    if (v > hi) begin
      r = {1'b1, 1'b0, {(DW-1){1'b1}}};
    end else if (v < lo) begin
      r = {1'b1, 1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, v[DW-1:0]};
    end
    return r;
  endfunction

endpackage

@@ rtl/vau_front.sv @@
// Front pipeline: operand select, multiply, combine, round, clamp.
// Uses vau_pkg. Five register stages, also emits the sum of squares of a.
module vau_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [2:0]                  cmd,
  input  logic signed [vau_pkg::DW-1:0] ax,
  input  logic signed [vau_pkg::DW-1:0] ay,
  input  logic signed [vau_pkg::DW-1:0] az,
  input  logic signed [vau_pkg::DW-1:0] bx,
  input  logic signed [vau_pkg::DW-1:0] by_comp,
  input  logic signed [vau_pkg::DW-1:0] bz,
  input  logic signed [vau_pkg::DW-1:0] factor,
  output logic                        out_valid,
  output vau_pkg::pl_t                out_pl,
  output logic [vau_pkg::P_W-1:0]     out_s
);
  import vau_pkg::*;

  localparam logic signed [W_W-1:0] HALF = W_W'(1) <<< (FW - 1);

  // stage 1: operands
  logic                  v1;
  op_t                   op1;
  logic signed [DW-1:0]  a1 [NLANE];
  logic signed [DW-1:0]  b1 [NLANE];
  logic signed [DW-1:0]  mx1 [NMUL];
  logic signed [DW-1:0]  my1 [NMUL];
  logic signed [DW-1:0]  mx_c [NMUL];
  logic signed [DW-1:0]  my_c [NMUL];
  op_t                   op_c;

  // stage 2: products
  logic                  v2;
  op_t                   op2;
  logic signed [DW-1:0]  a2 [NLANE];
  logic signed [AB_W-1:0] ab2 [NLANE];
  logic signed [P_W-1:0] p2 [NMUL];

  // stage 3: combined sums, lane 3 is the scalar
  logic                  v3;
  op_t                   op3;
  logic                  rnd3;
  logic signed [DW-1:0]  a3 [NLANE];
  logic signed [W_W-1:0] w3 [NLANE+1];
  logic signed [W_W-1:0] w_c [NLANE+1];

  // stage 4: rounded
  logic                  v4;
  op_t                   op4;
  logic signed [DW-1:0]  a4 [NLANE];
  logic signed [W_W-1:0] r4 [NLANE+1];
  logic [P_W-1:0]        s4;

  logic [DW:0]           cl_c [NLANE+1];
  logic                  vec_op;
  logic                  dot_op;

  assign op_c = op_t'(cmd);

  always_comb begin
    for (int k = 0; k < NMUL; k++) begin
      mx_c[k] = '0;
      my_c[k] = '0;
    end
    case (op_c)
      OP_SCALE: begin
        mx_c[0] = ax; my_c[0] = factor;
        mx_c[1] = ay; my_c[1] = factor;
        mx_c[2] = az; my_c[2] = factor;
      end
      OP_DOT: begin
        mx_c[0] = ax; my_c[0] = bx;
        mx_c[1] = ay; my_c[1] = by_comp;
        mx_c[2] = az; my_c[2] = bz;
      end
      OP_CROSS: begin
        mx_c[0] = ay; my_c[0] = bz;
        mx_c[1] = az; my_c[1] = bx;
        mx_c[2] = ax; my_c[2] = by_comp;
        mx_c[3] = az; my_c[3] = by_comp;
        mx_c[4] = ax; my_c[4] = bz;
        mx_c[5] = ay; my_c[5] = bx;
      end
      OP_LEN, OP_NORM: begin
        mx_c[0] = ax; my_c[0] = ax;
        mx_c[1] = ay; my_c[1] = ay;
        mx_c[2] = az; my_c[2] = az;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < NLANE + 1; i++) begin
      w_c[i] = '0;
    end
    for (int i = 0; i < NLANE; i++) begin
      case (op2)
        OP_ADD, OP_SUB: w_c[i] = W_W'(ab2[i]);
        OP_SCALE:       w_c[i] = W_W'(p2[i]);
        OP_CROSS:       w_c[i] = W_W'(p2[i]) - W_W'(p2[i+NLANE]);
        default:        w_c[i] = '0;
      endcase
    end
    w_c[NLANE] = W_W'(p2[0]) + W_W'(p2[1]) + W_W'(p2[2]);
  end

  always_comb begin
    for (int i = 0; i < NLANE + 1; i++) begin
      cl_c[i] = sat_clamp(r4[i]);
    end
  end

  assign vec_op = (op4 == OP_ADD) || (op4 == OP_SUB) || (op4 == OP_SCALE) ||
                  (op4 == OP_CROSS);
  assign dot_op = (op4 == OP_DOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1   <= op_c;
      a1[0] <= ax;
      a1[1] <= ay;
      a1[2] <= az;
      b1[0] <= bx;
      b1[1] <= by_comp;
      b1[2] <= bz;
      for (int k = 0; k < NMUL; k++) begin
        mx1[k] <= mx_c[k];
        my1[k] <= my_c[k];
      end

      op2 <= op1;
      for (int i = 0; i < NLANE; i++) begin
        a2[i]  <= a1[i];
        ab2[i] <= (op1 == OP_SUB) ? (AB_W'(a1[i]) - AB_W'(b1[i]))
                                  : (AB_W'(a1[i]) + AB_W'(b1[i]));
      end
      for (int k = 0; k < NMUL; k++) begin
        p2[k] <= P_W'(mx1[k]) * P_W'(my1[k]);
      end

      op3  <= op2;
      rnd3 <= (op2 == OP_SCALE) || (op2 == OP_DOT) || (op2 == OP_CROSS);
      for (int i = 0; i < NLANE; i++) begin
        a3[i] <= a2[i];
      end
      for (int i = 0; i < NLANE + 1; i++) begin
        w3[i] <= w_c[i];
      end

      // half-up rounding: floor((w + 2^(FW-1)) / 2^FW)
      op4 <= op3;
      s4  <= w3[NLANE][P_W-1:0];
      for (int i = 0; i < NLANE; i++) begin
        a4[i] <= a3[i];
      end
      for (int i = 0; i < NLANE + 1; i++) begin
        r4[i] <= rnd3 ? ((w3[i] + HALF) >>> FW) : w3[i];
      end

      out_s     <= s4;
      out_pl.op <= op4;
      out_pl.ax <= a4[0];
      out_pl.ay <= a4[1];
      out_pl.az <= a4[2];
      out_pl.rx <= vec_op ? cl_c[0][DW-1:0] : '0;
      out_pl.ry <= vec_op ? cl_c[1][DW-1:0] : '0;
      out_pl.rz <= vec_op ? cl_c[2][DW-1:0] : '0;
      out_pl.rs <= dot_op ? cl_c[NLANE][DW-1:0] : '0;
      out_pl.sat <= (vec_op && (cl_c[0][DW] || cl_c[1][DW] || cl_c[2][DW])) ||
                    (dot_op && cl_c[NLANE][DW]);
    end
  end

endmodule

@@ rtl/vau_sqrt.sv @@
// Pipelined rounded integer square root, one root bit per stage.
// Uses vau_pkg. Fills the scalar result for the length operation.
module vau_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  vau_pkg::pl_t               in_pl,
  input  logic [vau_pkg::P_W-1:0]    in_s,
  output logic                       out_valid,
  output vau_pkg::pl_t               out_pl,
  output logic [vau_pkg::LEN_W-1:0]  out_len
);
  import vau_pkg::*;

  logic           v_q   [SQ_STEPS];
  pl_t            pl_q  [SQ_STEPS];
  logic [P_W-1:0] rem_q [SQ_STEPS];
  logic [P_W-1:0] res_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [P_W-1:0] BIT = P_W'(1) << (P_W - 2 - 2 * k);
    logic           v_i;
    pl_t            pl_i;
    logic [P_W-1:0] rem_i;
    logic [P_W-1:0] res_i;
    logic [P_W-1:0] sum_c;
    logic           ge;

    if (k == 0) begin : g_first
      assign v_i   = in_valid;
      assign pl_i  = in_pl;
      assign rem_i = in_s;
      assign res_i = '0;
    end else begin : g_next
      assign v_i   = v_q[k-1];
      assign pl_i  = pl_q[k-1];
      assign rem_i = rem_q[k-1];
      assign res_i = res_q[k-1];
    end

    assign sum_c = res_i + BIT;
    assign ge    = (rem_i >= sum_c);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else if (en) begin
        v_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pl_q[k]  <= pl_i;
        rem_q[k] <= ge ? (rem_i - sum_c) : rem_i;
        res_q[k] <= ge ? ((res_i >> 1) + BIT) : (res_i >> 1);
      end
    end
  end

  logic [LEN_W-1:0] len_c;
  logic [DW:0]      cl_c;
  logic [P_W-1:0]   rem_l;
  logic [P_W-1:0]   res_l;
  pl_t              pl_c;

  assign rem_l = rem_q[SQ_STEPS-1];
  assign res_l = res_q[SQ_STEPS-1];
  // round to nearest: bump when the remainder exceeds the root
  assign len_c = res_l[LEN_W-1:0] + LEN_W'(rem_l > res_l);
  assign cl_c  = sat_clamp(W_W'(len_c));

  always_comb begin
    pl_c = pl_q[SQ_STEPS-1];
    if (pl_q[SQ_STEPS-1].op == OP_LEN) begin
      pl_c.rs  = cl_c[DW-1:0];
      pl_c.sat = cl_c[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_q[SQ_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_len <= len_c;
      out_pl  <= pl_c;
    end
  end

endmodule

@@ rtl/vau_div.sv @@
// Pipelined normalize divider, three lanes, one quotient bit per stage.
// Uses vau_pkg. Fills the vector result for the normalize operation.
module vau_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  vau_pkg::pl_t               in_pl,
  input  logic [vau_pkg::LEN_W-1:0]  in_len,
  output logic                       out_valid,
  output vau_pkg::pl_t               out_pl
);
  import vau_pkg::*;

  // prep stage: |a| * 2^FW + len/2
  logic             v0;
  pl_t              pl0;
  logic [LEN_W-1:0] len0;
  logic [DIV_W-1:0] rem0 [NLANE];
  logic [DW-1:0]    mag_c [NLANE];
  logic signed [DW-1:0] a_c [NLANE];

  assign a_c[0] = in_pl.ax;
  assign a_c[1] = in_pl.ay;
  assign a_c[2] = in_pl.az;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      mag_c[i] = a_c[i][DW-1] ? DW'(-a_c[i]) : DW'(a_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl0  <= in_pl;
      len0 <= in_len;
      for (int i = 0; i < NLANE; i++) begin
        rem0[i] <= DIV_W'((NUM_W'(mag_c[i]) << FW) + NUM_W'(in_len >> 1));
      end
    end
  end

  logic             v_q   [Q_W];
  pl_t              pl_q  [Q_W];
  logic [LEN_W-1:0] len_q [Q_W];
  logic [DIV_W-1:0] rem_q [Q_W][NLANE];
  logic [Q_W-1:0]   quo_q [Q_W][NLANE];

  for (genvar t = 0; t < Q_W; t++) begin : g_step
    logic             v_i;
    pl_t              pl_i;
    logic [LEN_W-1:0] len_i;
    logic [DIV_W-1:0] rem_i [NLANE];
    logic [Q_W-1:0]   quo_i [NLANE];
    logic [DIV_W-1:0] d_c;

    if (t == 0) begin : g_first
      assign v_i   = v0;
      assign pl_i  = pl0;
      assign len_i = len0;
      for (genvar i = 0; i < NLANE; i++) begin : g_lane
        assign rem_i[i] = rem0[i];
        assign quo_i[i] = '0;
      end
    end else begin : g_next
      assign v_i   = v_q[t-1];
      assign pl_i  = pl_q[t-1];
      assign len_i = len_q[t-1];
      for (genvar i = 0; i < NLANE; i++) begin : g_lane
        assign rem_i[i] = rem_q[t-1][i];
        assign quo_i[i] = quo_q[t-1][i];
      end
    end

    assign d_c = DIV_W'(len_i) << (Q_W - 1 - t);

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[t] <= 1'b0;
      end else if (en) begin
        v_q[t] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pl_q[t]  <= pl_i;
        len_q[t] <= len_i;
        for (int i = 0; i < NLANE; i++) begin
          if (rem_i[i] >= d_c) begin
            rem_q[t][i] <= rem_i[i] - d_c;
            quo_q[t][i] <= {quo_i[i][Q_W-2:0], 1'b1};
          end else begin
            rem_q[t][i] <= rem_i[i];
            quo_q[t][i] <= {quo_i[i][Q_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // final: restore sign; zero-length vector passes through unchanged
  pl_t                  pl_l;
  pl_t                  pl_c;
  logic signed [DW-1:0] al_c [NLANE];
  logic signed [DW-1:0] nv_c [NLANE];
  logic signed [DW-1:0] qs_c [NLANE];
  logic                 zero_len;

  assign pl_l     = pl_q[Q_W-1];
  assign al_c[0]  = pl_l.ax;
  assign al_c[1]  = pl_l.ay;
  assign al_c[2]  = pl_l.az;
  assign zero_len = (len_q[Q_W-1] == '0);

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      qs_c[i] = DW'(quo_q[Q_W-1][i]);
      if (zero_len) begin
        nv_c[i] = al_c[i];
      end else begin
        nv_c[i] = al_c[i][DW-1] ? -qs_c[i] : qs_c[i];
      end
    end
  end

  always_comb begin
    pl_c = pl_l;
    if (pl_l.op == OP_NORM) begin
      pl_c.rx = nv_c[0];
      pl_c.ry = nv_c[1];
      pl_c.rz = nv_c[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_q[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pl <= pl_c;
    end
  end

endmodule

@@ rtl/vector3_arithmetic_unit.sv @@
// Top level of the 3D vector unit: front, root and divider pipelines, output skid.
// Uses vau_pkg, vau_front, vau_sqrt, vau_div and assert_macros.svh.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | request   | in_valid / in_ready | cmd ax ay az bx by_comp bz factor
//  out     | result    | out_valid/out_ready | res_x res_y res_z res_scalar saturated
//
// One request enters per cycle while in_ready is high; every request takes the
// same pipe path (front, root, divider), then the output register, so results
// leave in order. Depth is set by the root (one bit per stage) and the normalize
// divider (one quotient bit per stage). Reset clears only valid bits.
// On a stall the pipe keeps moving until a result lands in the skid register;
// then in_ready drops and the whole pipe holds until the output is taken.
`include "assert_macros.svh"
module vector3_arithmetic_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    cmd,
  input  logic signed [vau_pkg::DW-1:0] ax,
  input  logic signed [vau_pkg::DW-1:0] ay,
  input  logic signed [vau_pkg::DW-1:0] az,
  input  logic signed [vau_pkg::DW-1:0] bx,
  input  logic signed [vau_pkg::DW-1:0] by_comp,
  input  logic signed [vau_pkg::DW-1:0] bz,
  input  logic signed [vau_pkg::DW-1:0] factor,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [vau_pkg::DW-1:0] res_x,
  output logic signed [vau_pkg::DW-1:0] res_y,
  output logic signed [vau_pkg::DW-1:0] res_z,
  output logic signed [vau_pkg::DW-1:0] res_scalar,
  output logic                          saturated
);
  import vau_pkg::*;

  logic             en;       // whole pipe advances together
  logic             fr_v;
  pl_t              fr_pl;
  logic [P_W-1:0]   fr_s;     // sum of squares of a for length and normalize
  logic             sq_v;
  pl_t              sq_pl;
  logic [LEN_W-1:0] sq_len;   // rounded length
  logic             dv_v;
  pl_t              dv_pl;
  logic             push;     // result leaving the pipe this cycle

  logic             skid_v;
  pl_t              skid_q;
  pl_t              out_q;

  // Pipe runs whenever the skid is empty; the skid catches the one result
  // that can arrive while the output register is stalled.
  assign en       = !skid_v;
  assign in_ready = en;
  assign push     = dv_v && en;

  vau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .ax        (ax),
    .ay        (ay),
    .az        (az),
    .bx        (bx),
    .by_comp   (by_comp),
    .bz        (bz),
    .factor    (factor),
    .out_valid (fr_v),
    .out_pl    (fr_pl),
    .out_s     (fr_s)
  );

  vau_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (fr_v),
    .in_pl     (fr_pl),
    .in_s      (fr_s),
    .out_valid (sq_v),
    .out_pl    (sq_pl),
    .out_len   (sq_len)
  );

  vau_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v),
    .in_pl     (sq_pl),
    .in_len    (sq_len),
    .out_valid (dv_v),
    .out_pl    (dv_pl)
  );

  // Output register plus skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_v) begin
        out_valid <= 1'b1;
        skid_v    <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_q <= skid_v ? skid_q : dv_pl;
    end else if (push) begin
      skid_q <= dv_pl;
    end
  end

  assign res_x      = out_q.rx;
  assign res_y      = out_q.ry;
  assign res_z      = out_q.rz;
  assign res_scalar = out_q.rs;
  assign saturated  = out_q.sat;

  // skid only fills behind a waiting output
  `VAU_CHECK(a_skid_has_out, skid_v |-> out_valid)
  // a held skid result is not dropped while the output stalls
  `VAU_CHECK(a_skid_kept, (skid_v && out_valid && !out_ready) |=> skid_v)
  // normalize results never carry the saturation flag
  `VAU_CHECK(a_norm_no_sat, (out_valid && out_q.op == OP_NORM) |-> !saturated)
  // length returns a scalar only
  `VAU_NEVER(a_len_vec, out_valid && out_q.op == OP_LEN &&
    (res_x != '0 || res_y != '0 || res_z != '0))

endmodule
